[hdl/traffic_light_controller_unit_macros.svh]
// Assertion macros for the traffic light controller unit.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef TRAFFIC_LIGHT_CONTROLLER_UNIT_MACROS_SVH
`define TRAFFIC_LIGHT_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define TLC_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("tlc check failed: same-cycle implication");
`define TLC_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("tlc check failed: next-cycle implication");
`else
`define TLC_ASSERT_IMP(name, clk_s, rst_s, ante, cons)
`define TLC_ASSERT_NXT(name, clk_s, rst_s, ante, cons)
`endif

`endif

[hdl/tlc_pkg.sv]
// Shared types, constants and helpers for the traffic light controller.
// No dependencies; used by tlc_cfg, tlc_disp, traffic_light_controller_unit and the bench.
`timescale 1ns / 1ps

package tlc_pkg;

  localparam int LEN_W = 7;
  localparam int CNT_W = 8;
  localparam int TMR_W = 10;
  localparam int PT_W  = 17;
  localparam int MNUM_W = 3;
  localparam int LAMP_W = 6;
  localparam int SEG_W = 7;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [LEN_W-1:0] MAX_TIME    = 7'd99;
  localparam logic [LEN_W-1:0] RED_RESET   = 7'd5;
  localparam logic [LEN_W-1:0] AMBER_RESET = 7'd2;
  localparam logic [LEN_W-1:0] GREEN_RESET = 7'd3;
  localparam logic [TMR_W-1:0] TPS_RESET   = 10'd100;
  localparam logic [TMR_W-1:0] BHT_RESET   = 10'd50;
  localparam logic [PT_W-1:0]  GREEN_PROD_RESET = PT_W'(GREEN_RESET * TPS_RESET);
  localparam logic [PT_W-1:0]  AMBER_PROD_RESET = PT_W'(AMBER_RESET * TPS_RESET);

  localparam logic REG_TPS = 1'b0;
  localparam logic REG_BHT = 1'b1;

  localparam logic [MNUM_W-1:0] MODE_NUM_NORMAL = 3'd1;
  localparam logic [MNUM_W-1:0] MODE_NUM_RED    = 3'd2;
  localparam logic [MNUM_W-1:0] MODE_NUM_AMBER  = 3'd3;
  localparam logic [MNUM_W-1:0] MODE_NUM_GREEN  = 3'd4;

  localparam logic [LAMP_W-1:0] LAMPS_OFF  = 6'h00;
  localparam logic [LAMP_W-1:0] LAMPS_R1G2 = 6'h21;
  localparam logic [LAMP_W-1:0] LAMPS_R1A2 = 6'h11;
  localparam logic [LAMP_W-1:0] LAMPS_G1R2 = 6'h0C;
  localparam logic [LAMP_W-1:0] LAMPS_A1R2 = 6'h0A;
  localparam logic [LAMP_W-1:0] LAMPS_REDS = 6'h09;
  localparam logic [LAMP_W-1:0] LAMPS_AMBS = 6'h12;
  localparam logic [LAMP_W-1:0] LAMPS_GRNS = 6'h24;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_RED    = 4'b0010,
    MODE_AMBER  = 4'b0100,
    MODE_GREEN  = 4'b1000
  } mode_t;

  typedef enum logic [3:0] {
    PH_R1G2 = 4'b0001,
    PH_R1A2 = 4'b0010,
    PH_G1R2 = 4'b0100,
    PH_A1R2 = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [TMR_W-1:0] tps;
    logic [TMR_W-1:0] bht;
    logic [TMR_W-1:0] tps_next;
  } cfg_t;

  function automatic logic [MNUM_W-1:0] mode_num(input mode_t m);
    logic [MNUM_W-1:0] n;
    unique case (m)
      MODE_NORMAL: n = MODE_NUM_NORMAL;
      MODE_RED:    n = MODE_NUM_RED;
      MODE_AMBER:  n = MODE_NUM_AMBER;
      MODE_GREEN:  n = MODE_NUM_GREEN;
      default:     n = MODE_NUM_NORMAL;
    endcase
    return n;
  endfunction

  function automatic mode_t mode_succ(input mode_t m);
    mode_t n;
    unique case (m)
      MODE_NORMAL: n = MODE_RED;
      MODE_RED:    n = MODE_AMBER;
      MODE_AMBER:  n = MODE_GREEN;
      default:     n = MODE_NORMAL;
    endcase
    return n;
  endfunction

  function automatic logic [LAMP_W-1:0] phase_lamps(input phase_t p);
    logic [LAMP_W-1:0] l;
    unique case (p)
      PH_R1G2: l = LAMPS_R1G2;
      PH_R1A2: l = LAMPS_R1A2;
      PH_G1R2: l = LAMPS_G1R2;
      PH_A1R2: l = LAMPS_A1R2;
      default: l = LAMPS_R1G2;
    endcase
    return l;
  endfunction

  function automatic logic [LAMP_W-1:0] edit_lamps(input mode_t m);
    logic [LAMP_W-1:0] l;
    unique case (m)
      MODE_RED:   l = LAMPS_REDS;
      MODE_AMBER: l = LAMPS_AMBS;
      MODE_GREEN: l = LAMPS_GRNS;
      default:    l = LAMPS_OFF;
    endcase
    return l;
  endfunction

endpackage

[hdl/traffic_light_controller_unit.sv]
// Top level of the two-way traffic light controller: tick handshake, state update,
// result register. Depends on tlc_pkg, tlc_cfg, tlc_disp and the macros header.
//
//   channel  signals                                   direction  width
//   tick     tick_valid/tick_ready, *_press           in         1 each
//   result   res_valid/res_ready, lamp_pattern, seg_*  out        6, 7 x4, 3
//   config   psel/penable/pwrite/paddr/pwdata/prdata   in/out     32-bit data
//
// A tick beat per cycle unless res_ready stalls; its result is valid the next cycle.
// The whole tick update (buttons, init, timers, phase step) is one combinational pass
// from the state registers; phase products are held in registers tracking lengths.
// A tick beat is taken whenever the result register is empty or being drained.
// rst is synchronous and loads the power-on timings; no clearing pass.
`timescale 1ns / 1ps
`include "traffic_light_controller_unit_macros.svh"

module traffic_light_controller_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlc_pkg::ADDR_W-1:0]    paddr,
  input  logic [tlc_pkg::DATA_W-1:0]    pwdata,
  output logic [tlc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          tick_valid,
  output logic                          tick_ready,
  input  logic                          mode_press,
  input  logic                          raise_press,
  input  logic                          save_press,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [tlc_pkg::LAMP_W-1:0]    lamp_pattern,
  output logic [tlc_pkg::SEG_W-1:0]     seg_left_tens,
  output logic [tlc_pkg::SEG_W-1:0]     seg_left_ones,
  output logic [tlc_pkg::SEG_W-1:0]     seg_right_tens,
  output logic [tlc_pkg::SEG_W-1:0]     seg_right_ones,
  output logic [tlc_pkg::MNUM_W-1:0]    mode_now
);
  import tlc_pkg::*;

  cfg_t cfg;

  mode_t            mode, mode_next;
  phase_t           phase, phase_next;
  logic [LEN_W-1:0] red_len, red_len_next;
  logic [LEN_W-1:0] amber_len, amber_len_next;
  logic [LEN_W-1:0] green_len, green_len_next;
  logic [LEN_W-1:0] edit_red, edit_red_next;
  logic [LEN_W-1:0] edit_amber, edit_amber_next;
  logic [LEN_W-1:0] edit_green, edit_green_next;
  logic [CNT_W-1:0] left_count, left_count_next;
  logic [CNT_W-1:0] right_count, right_count_next;
  logic [PT_W-1:0]  phase_timer, phase_timer_next;
  logic [TMR_W-1:0] second_timer, second_timer_next;
  logic [TMR_W-1:0] blink_timer, blink_timer_next;
  logic             blink_on, blink_on_next;
  logic [PT_W-1:0]  green_prod, amber_prod;

  logic             accept;
  logic             init;
  logic [CNT_W-1:0] ga_sum;
  logic [LAMP_W-1:0] lamp_next;
  logic [CNT_W-1:0] left_val, right_val;
  logic [SEG_W-1:0] lt_next, lo_next, rt_next, ro_next;
  logic [LEN_W-1:0] green_len_d, amber_len_d;

  tlc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign tick_ready = !res_valid || res_ready;
  assign accept     = tick_valid && tick_ready;
  assign ga_sum     = {1'b0, green_len} + {1'b0, amber_len};

  always_comb begin
    mode_next         = mode;
    phase_next        = phase;
    red_len_next      = red_len;
    amber_len_next    = amber_len;
    green_len_next    = green_len;
    edit_red_next     = edit_red;
    edit_amber_next   = edit_amber;
    edit_green_next   = edit_green;
    left_count_next   = left_count;
    right_count_next  = right_count;
    phase_timer_next  = phase_timer;
    second_timer_next = second_timer;
    blink_timer_next  = blink_timer;
    blink_on_next     = blink_on;
    init              = 1'b0;
    lamp_next         = LAMPS_OFF;
    left_val          = left_count;
    right_val         = right_count;

    if (mode_press) begin
      if (mode == MODE_GREEN) begin
        mode_next = MODE_NORMAL;
        init      = 1'b1;
      end else begin
        mode_next        = mode_succ(mode);
        edit_red_next    = red_len;
        edit_amber_next  = amber_len;
        edit_green_next  = green_len;
        blink_timer_next = cfg.bht;
        blink_on_next    = 1'b0;
      end
    end

    if (!init) begin
      if (raise_press) begin
        case (mode_next)
          MODE_RED:   if (edit_red_next < MAX_TIME) edit_red_next = edit_red_next + 7'd1;
          MODE_AMBER: if (edit_amber_next < MAX_TIME) edit_amber_next = edit_amber_next + 7'd1;
          MODE_GREEN: if (edit_green_next < MAX_TIME) edit_green_next = edit_green_next + 7'd1;
          default: ;
        endcase
      end
      if (save_press) begin
        case (mode_next)
          MODE_RED:   red_len_next   = edit_red_next;
          MODE_AMBER: amber_len_next = edit_amber_next;
          MODE_GREEN: green_len_next = edit_green_next;
          default: ;
        endcase
      end
    end

    if (mode_next == MODE_NORMAL && ga_sum != {1'b0, red_len}) init = 1'b1;

    if (init) begin
      edit_red_next     = red_len;
      edit_amber_next   = amber_len;
      edit_green_next   = green_len;
      phase_next        = PH_R1G2;
      left_count_next   = ga_sum;
      right_count_next  = {1'b0, green_len};
      phase_timer_next  = green_prod;
      second_timer_next = cfg.tps;
      blink_timer_next  = cfg.bht;
      blink_on_next     = 1'b0;
    end

    if (mode_next == MODE_NORMAL) begin
      if (second_timer_next != '0) second_timer_next = second_timer_next - 10'd1;
      if (second_timer_next == '0) begin
        second_timer_next = cfg.tps;
        if (left_count_next > 8'd1) left_count_next = left_count_next - 8'd1;
        if (right_count_next > 8'd1) right_count_next = right_count_next - 8'd1;
      end
      if (phase_timer_next != '0) phase_timer_next = phase_timer_next - 17'd1;
      if (phase_timer_next == '0) begin
        unique case (phase_next)
          PH_R1G2: begin
            left_count_next  = {1'b0, amber_len};
            right_count_next = {1'b0, amber_len};
            phase_timer_next = amber_prod;
            phase_next       = PH_R1A2;
          end
          PH_R1A2: begin
            left_count_next  = {1'b0, green_len};
            right_count_next = ga_sum;
            phase_timer_next = green_prod;
            phase_next       = PH_G1R2;
          end
          PH_G1R2: begin
            left_count_next  = {1'b0, amber_len};
            right_count_next = {1'b0, amber_len};
            phase_timer_next = amber_prod;
            phase_next       = PH_A1R2;
          end
          default: begin
            left_count_next  = ga_sum;
            right_count_next = {1'b0, green_len};
            phase_timer_next = green_prod;
            phase_next       = PH_R1G2;
          end
        endcase
      end
      lamp_next = phase_lamps(phase_next);
      left_val  = left_count_next;
      right_val = right_count_next;
    end else begin
      if (blink_timer_next != '0) blink_timer_next = blink_timer_next - 10'd1;
      if (blink_timer_next == '0) begin
        blink_timer_next = cfg.bht;
        blink_on_next    = !blink_on_next;
      end
      lamp_next = blink_on_next ? edit_lamps(mode_next) : LAMPS_OFF;
      case (mode_next)
        MODE_RED:   left_val = {1'b0, edit_red_next};
        MODE_AMBER: left_val = {1'b0, edit_amber_next};
        default:    left_val = {1'b0, edit_green_next};
      endcase
      right_val = CNT_W'(mode_num(mode_next));
    end
  end

  tlc_disp u_disp (
    .left_val   (left_val),
    .right_val  (right_val),
    .left_tens  (lt_next),
    .left_ones  (lo_next),
    .right_tens (rt_next),
    .right_ones (ro_next)
  );

  // phase products follow the lengths and rate as they will be after this edge
  assign green_len_d = accept ? green_len_next : green_len;
  assign amber_len_d = accept ? amber_len_next : amber_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      green_prod <= GREEN_PROD_RESET;
      amber_prod <= AMBER_PROD_RESET;
    end else begin
      green_prod <= PT_W'(green_len_d) * PT_W'(cfg.tps_next);
      amber_prod <= PT_W'(amber_len_d) * PT_W'(cfg.tps_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      phase        <= PH_R1G2;
      red_len      <= RED_RESET;
      amber_len    <= AMBER_RESET;
      green_len    <= GREEN_RESET;
      edit_red     <= RED_RESET;
      edit_amber   <= AMBER_RESET;
      edit_green   <= GREEN_RESET;
      left_count   <= {1'b0, GREEN_RESET} + {1'b0, AMBER_RESET};
      right_count  <= {1'b0, GREEN_RESET};
      phase_timer  <= GREEN_PROD_RESET;
      second_timer <= TPS_RESET;
      blink_timer  <= BHT_RESET;
      blink_on     <= 1'b0;
    end else if (accept) begin
      mode         <= mode_next;
      phase        <= phase_next;
      red_len      <= red_len_next;
      amber_len    <= amber_len_next;
      green_len    <= green_len_next;
      edit_red     <= edit_red_next;
      edit_amber   <= edit_amber_next;
      edit_green   <= edit_green_next;
      left_count   <= left_count_next;
      right_count  <= right_count_next;
      phase_timer  <= phase_timer_next;
      second_timer <= second_timer_next;
      blink_timer  <= blink_timer_next;
      blink_on     <= blink_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lamp_pattern   <= lamp_next;
      seg_left_tens  <= lt_next;
      seg_left_ones  <= lo_next;
      seg_right_tens <= rt_next;
      seg_right_ones <= ro_next;
      mode_now       <= mode_num(mode_next);
    end
  end

  `TLC_ASSERT_NXT(a_accept_fills, clk, rst, tick_valid && tick_ready, res_valid)
  `TLC_ASSERT_IMP(a_counts_nonzero, clk, rst, 1'b1, left_count != '0 && right_count != '0)
  `TLC_ASSERT_IMP(a_len_bound, clk, rst, 1'b1, red_len <= MAX_TIME && amber_len <= MAX_TIME && green_len <= MAX_TIME)
  `TLC_ASSERT_IMP(a_normal_lamps, clk, rst, res_valid && mode_now == MODE_NUM_NORMAL, $countones(lamp_pattern) == 2)

endmodule

[hdl/tlc_cfg.sv]
// APB-style register block: ticks_per_second and blink_half_ticks.
// Depends on tlc_pkg.
`timescale 1ns / 1ps

module tlc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tlc_pkg::DATA_W-1:0]  pwdata,
  output logic [tlc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tlc_pkg::cfg_t               cfg
);
  import tlc_pkg::*;

  logic [TMR_W-1:0] tps;
  logic [TMR_W-1:0] bht;
  logic             wr;
  logic             idx;
  logic [TMR_W-1:0] tps_next;
  logic [TMR_W-1:0] bht_next;

  assign pready = 1'b1;
  assign idx    = paddr[2];
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    tps_next = tps;
    bht_next = bht;
    if (wr) begin
      unique case (idx)
        REG_TPS: tps_next = pwdata[TMR_W-1:0];
        REG_BHT: bht_next = pwdata[TMR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
      bht <= BHT_RESET;
    end else begin
      tps <= tps_next;
      bht <= bht_next;
    end
  end

  always_comb begin
    unique case (idx)
      REG_TPS: prdata = {{(DATA_W-TMR_W){1'b0}}, tps};
      REG_BHT: prdata = {{(DATA_W-TMR_W){1'b0}}, bht};
      default: prdata = '0;
    endcase
  end

  assign cfg.tps      = tps;
  assign cfg.bht      = bht;
  assign cfg.tps_next = tps_next;

endmodule

[hdl/tlc_disp.sv]
// Display encoder: clamps two values to 99 and maps each digit to a segment code.
// Depends on tlc_pkg.
`timescale 1ns / 1ps

module tlc_disp (
  input  logic [tlc_pkg::CNT_W-1:0] left_val,
  input  logic [tlc_pkg::CNT_W-1:0] right_val,
  output logic [tlc_pkg::SEG_W-1:0] left_tens,
  output logic [tlc_pkg::SEG_W-1:0] left_ones,
  output logic [tlc_pkg::SEG_W-1:0] right_tens,
  output logic [tlc_pkg::SEG_W-1:0] right_ones
);
  import tlc_pkg::*;

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // tens = v*205 >> 11 is exact for v up to 99
  function automatic logic [2*SEG_W-1:0] encode(input logic [CNT_W-1:0] v);
    logic [LEN_W-1:0] c;
    logic [14:0]      prod;
    logic [3:0]       tens;
    logic [LEN_W-1:0] ones;
    c    = (v > {1'b0, MAX_TIME}) ? MAX_TIME : v[LEN_W-1:0];
    prod = 15'(c) * 15'd205;
    tens = prod[14:11];
    ones = c - LEN_W'(tens) * LEN_W'(10);
    return {seg_code(tens), seg_code(ones[3:0])};
  endfunction

  assign {left_tens, left_ones}   = encode(left_val);
  assign {right_tens, right_ones} = encode(right_val);

endmodule

[tb/tb_top.sv]
// Self-checking bench for traffic_light_controller_unit: directed and random tick beats
// checked against a tick-level prediction of lamps, digit codes and mode number.
// Depends on tlc_pkg and the unit RTL; registers are written over APB between phases.
`timescale 1ns / 1ps

module tb_top;
  import tlc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [LAMP_W-1:0] lamps;
    logic [SEG_W-1:0]  left_tens;
    logic [SEG_W-1:0]  left_ones;
    logic [SEG_W-1:0]  right_tens;
    logic [SEG_W-1:0]  right_ones;
    logic [MNUM_W-1:0] mode_num;
  } display_t;

  class junction_board;
    logic [TMR_W-1:0] tps, bht;
    mode_t            mode;
    phase_t           phase;
    logic [LEN_W-1:0] red_len, amber_len, green_len;
    logic [LEN_W-1:0] work_red, work_amber, work_green;
    logic [CNT_W-1:0] left_cnt, right_cnt;
    logic [PT_W-1:0]  phase_tmr;
    logic [TMR_W-1:0] sec_tmr, blink_tmr;
    bit               blink_on;
    display_t         due_displays[$];
    int               errors;

    function new();
      tps = TPS_RESET;
      bht = BHT_RESET;
      red_len = RED_RESET;
      amber_len = AMBER_RESET;
      green_len = GREEN_RESET;
      errors = 0;
      restart_cycle();
    endfunction

    function void set_reg(logic idx, logic [TMR_W-1:0] v);
      if (idx == REG_TPS) tps = v;
      else bht = v;
    endfunction

    function void restart_cycle();
      work_red = red_len;
      work_amber = amber_len;
      work_green = green_len;
      mode = MODE_NORMAL;
      phase = PH_R1G2;
      left_cnt = CNT_W'(green_len) + CNT_W'(amber_len);
      right_cnt = CNT_W'(green_len);
      phase_tmr = PT_W'(green_len) * PT_W'(tps);
      sec_tmr = tps;
      blink_tmr = bht;
      blink_on = 0;
    endfunction

    function void advance_phase();
      case (phase)
        PH_R1G2: begin
          left_cnt = CNT_W'(amber_len);
          right_cnt = CNT_W'(amber_len);
          phase_tmr = PT_W'(amber_len) * PT_W'(tps);
          phase = PH_R1A2;
        end
        PH_R1A2: begin
          left_cnt = CNT_W'(green_len);
          right_cnt = CNT_W'(amber_len) + CNT_W'(green_len);
          phase_tmr = PT_W'(green_len) * PT_W'(tps);
          phase = PH_G1R2;
        end
        PH_G1R2: begin
          left_cnt = CNT_W'(amber_len);
          right_cnt = CNT_W'(amber_len);
          phase_tmr = PT_W'(amber_len) * PT_W'(tps);
          phase = PH_A1R2;
        end
        default: begin
          left_cnt = CNT_W'(amber_len) + CNT_W'(green_len);
          right_cnt = CNT_W'(green_len);
          phase_tmr = PT_W'(green_len) * PT_W'(tps);
          phase = PH_R1G2;
        end
      endcase
    endfunction

    function logic [MNUM_W-1:0] mode_number();
      case (mode)
        MODE_RED:   return MODE_NUM_RED;
        MODE_AMBER: return MODE_NUM_AMBER;
        MODE_GREEN: return MODE_NUM_GREEN;
        default:    return MODE_NUM_NORMAL;
      endcase
    endfunction

    function logic [LAMP_W-1:0] run_lamps();
      case (phase)
        PH_R1A2: return LAMPS_R1A2;
        PH_G1R2: return LAMPS_G1R2;
        PH_A1R2: return LAMPS_A1R2;
        default: return LAMPS_R1G2;
      endcase
    endfunction

    function logic [LAMP_W-1:0] blink_lamps();
      case (mode)
        MODE_RED:   return LAMPS_REDS;
        MODE_AMBER: return LAMPS_AMBS;
        default:    return LAMPS_GRNS;
      endcase
    endfunction

    function logic [SEG_W-1:0] seg_of(int d);
      case (d)
        0:       return 7'h3F;
        1:       return 7'h06;
        2:       return 7'h5B;
        3:       return 7'h4F;
        4:       return 7'h66;
        5:       return 7'h6D;
        6:       return 7'h7D;
        7:       return 7'h07;
        8:       return 7'h7F;
        default: return 7'h6F;
      endcase
    endfunction

    function void split(input logic [CNT_W-1:0] v, output logic [SEG_W-1:0] tens,
                        output logic [SEG_W-1:0] ones);
      int x;
      x = (v > MAX_TIME) ? int'(MAX_TIME) : int'(v);
      tens = seg_of(x / 10);
      ones = seg_of(x % 10);
    endfunction

    function void note_tick(bit mp, bit rp, bit sp);
      display_t d;
      bit left_edit;
      logic [CNT_W-1:0] lv, rv;
      left_edit = 0;
      if (mp) begin
        if (mode == MODE_GREEN) begin
          restart_cycle();
          left_edit = 1;
        end else begin
          case (mode)
            MODE_NORMAL: mode = MODE_RED;
            MODE_RED:    mode = MODE_AMBER;
            default:     mode = MODE_GREEN;
          endcase
          work_red = red_len;
          work_amber = amber_len;
          work_green = green_len;
          blink_tmr = bht;
          blink_on = 0;
        end
      end
      if (!left_edit) begin
        if (rp) begin
          case (mode)
            MODE_RED:   if (work_red < MAX_TIME) work_red++;
            MODE_AMBER: if (work_amber < MAX_TIME) work_amber++;
            MODE_GREEN: if (work_green < MAX_TIME) work_green++;
            default: ;
          endcase
        end
        if (sp) begin
          case (mode)
            MODE_RED:   red_len = work_red;
            MODE_AMBER: amber_len = work_amber;
            MODE_GREEN: green_len = work_green;
            default: ;
          endcase
        end
      end
      if (mode == MODE_NORMAL) begin
        if (CNT_W'(green_len) + CNT_W'(amber_len) != CNT_W'(red_len)) restart_cycle();
        if (sec_tmr != 0) sec_tmr--;
        if (sec_tmr == 0) begin
          sec_tmr = tps;
          if (left_cnt > 1) left_cnt--;
          if (right_cnt > 1) right_cnt--;
        end
        if (phase_tmr != 0) phase_tmr--;
        if (phase_tmr == 0) advance_phase();
        d.lamps = run_lamps();
        lv = left_cnt;
        rv = right_cnt;
      end else begin
        if (blink_tmr != 0) blink_tmr--;
        if (blink_tmr == 0) begin
          blink_tmr = bht;
          blink_on = !blink_on;
        end
        d.lamps = blink_on ? blink_lamps() : LAMPS_OFF;
        case (mode)
          MODE_RED:   lv = CNT_W'(work_red);
          MODE_AMBER: lv = CNT_W'(work_amber);
          default:    lv = CNT_W'(work_green);
        endcase
        rv = CNT_W'(mode_number());
      end
      split(lv, d.left_tens, d.left_ones);
      split(rv, d.right_tens, d.right_ones);
      d.mode_num = mode_number();
      due_displays.push_back(d);
    endfunction

    function void flag(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %h, got %h", field, want, got);
    endfunction

    function void check_display(display_t got);
      display_t want;
      if (due_displays.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result beat with no tick pending: lamps %h mode %h", got.lamps, got.mode_num);
        return;
      end
      want = due_displays.pop_front();
      if (got.lamps !== want.lamps) flag("lamp_pattern", 8'(want.lamps), 8'(got.lamps));
      if (got.left_tens !== want.left_tens)
        flag("seg_left_tens", 8'(want.left_tens), 8'(got.left_tens));
      if (got.left_ones !== want.left_ones)
        flag("seg_left_ones", 8'(want.left_ones), 8'(got.left_ones));
      if (got.right_tens !== want.right_tens)
        flag("seg_right_tens", 8'(want.right_tens), 8'(got.right_tens));
      if (got.right_ones !== want.right_ones)
        flag("seg_right_ones", 8'(want.right_ones), 8'(got.right_ones));
      if (got.mode_num !== want.mode_num)
        flag("mode_now", 8'(want.mode_num), 8'(got.mode_num));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic tick_valid = 1'b0;
  logic tick_ready;
  logic mode_press = 1'b0;
  logic raise_press = 1'b0;
  logic save_press = 1'b0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic [LAMP_W-1:0] lamp_pattern;
  logic [SEG_W-1:0] seg_left_tens, seg_left_ones, seg_right_tens, seg_right_ones;
  logic [MNUM_W-1:0] mode_now;

  junction_board board;
  int sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  traffic_light_controller_unit u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .tick_valid(tick_valid),
    .tick_ready(tick_ready),
    .mode_press(mode_press),
    .raise_press(raise_press),
    .save_press(save_press),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .lamp_pattern(lamp_pattern),
    .seg_left_tens(seg_left_tens),
    .seg_left_ones(seg_left_ones),
    .seg_right_tens(seg_right_tens),
    .seg_right_ones(seg_right_ones),
    .mode_now(mode_now)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      res_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      res_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    display_t got;
    if (!rst && res_valid && res_ready) begin
      got = {lamp_pattern, seg_left_tens, seg_left_ones, seg_right_tens, seg_right_ones,
             mode_now};
      board.check_display(got);
    end
  end

  task automatic send_tick(input bit mp, input bit rp, input bit sp);
    while ($urandom_range(99) < idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    mode_press <= mp;
    raise_press <= rp;
    save_press <= sp;
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
    board.note_tick(mp, rp, sp);
    sent++;
  endtask

  task automatic plain_ticks(input int n);
    repeat (n) send_tick(1'b0, 1'b0, 1'b0);
  endtask

  task automatic reg_write(input logic idx, input logic [TMR_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_reg(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    tick_valid <= 1'b0;
    while (board.due_displays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [TMR_W-1:0] tps, input logic [TMR_W-1:0] bht,
                           input int idle, input int stall);
    drain();
    idle_pct = idle;
    stall_pct = stall;
    reg_write(REG_TPS, tps);
    reg_write(REG_BHT, bht);
  endtask

  // enter the next edit mode, raise the working time, then save it if keep is set
  task automatic edit_stage(input int raises, input bit keep);
    int k;
    bit fold;
    bit saved;
    fold = (raises > 0) && ($urandom_range(1) == 1);
    saved = 0;
    send_tick(1'b1, fold, 1'b0);
    for (k = fold ? 1 : 0; k < raises; k++) begin
      if ($urandom_range(3) == 0) plain_ticks($urandom_range(1, 3));
      saved = keep && (k == raises - 1) && ($urandom_range(1) == 1);
      send_tick(1'b0, 1'b1, saved);
    end
    if (keep && !saved) send_tick(1'b0, 1'b0, 1'b1);
  endtask

  // pick new lengths, normally red equal to amber plus green, then walk all edit modes; red is left unsaved at random
  task automatic edit_cycle();
    int r0, a0, g0, na, ng, nr;
    bit broken;
    while (board.mode != MODE_NORMAL) send_tick(1'b1, 1'b0, 1'b0);
    r0 = int'(board.red_len);
    a0 = int'(board.amber_len);
    g0 = int'(board.green_len);
    na = a0 + int'($urandom_range(1));
    ng = g0 + int'($urandom_range(1));
    if (na > int'(MAX_TIME)) na = int'(MAX_TIME);
    if (ng > int'(MAX_TIME)) ng = int'(MAX_TIME);
    nr = na + ng;
    if (nr < r0) begin
      ng = ng + r0 - nr;
      nr = r0;
    end
    if (ng > int'(MAX_TIME) || nr > int'(MAX_TIME)) begin
      na = a0;
      ng = g0;
      nr = r0;
    end
    broken = ($urandom_range(9) == 0);
    edit_stage(nr - r0, !broken);
    edit_stage(na - a0, 1'b1);
    edit_stage(ng - g0, 1'b1);
    send_tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
    plain_ticks($urandom_range(3, 30));
  endtask

  task automatic raise_to_limit();
    while (board.mode != MODE_NORMAL) send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    repeat (100) send_tick(1'b0, 1'b1, 1'b0);
    repeat (3) send_tick(1'b1, 1'b0, 1'b0);
  endtask

  task automatic random_items(input int n);
    int goal, pick;
    goal = sent + n;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 60) edit_cycle();
      else if (pick < 85) plain_ticks($urandom_range(5, 40));
      else repeat ($urandom_range(1, 6))
        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    board = new();
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    plain_ticks(2);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    repeat (3) send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    plain_ticks(3);

    configure(10'd1, 10'd1, 0, 0);
    random_items(260);
    configure(10'd2, 10'd3, 64, 0);
    raise_to_limit();
    random_items(150);
    configure(10'd0, 10'd0, 0, 64);
    random_items(200);
    configure(10'd1023, 10'd1023, 27, 27);
    random_items(150);
    configure(10'd4, 10'd2, 0, 0);
    hold_requests++;
    random_items(300);

    drain();
    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.due_displays.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
